/* hdl/offset_coincidence_counter_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef OFFSET_COINCIDENCE_COUNTER_UNIT_DEFINES_SVH
`define OFFSET_COINCIDENCE_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define OCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define OCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays armed through reset.
`define OCC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/occ_pkg.sv */
`timescale 1ns / 1ps
package occ_pkg;

  localparam int MAX_OFFSET  = 64;
  localparam int OFFSET_W    = 7;
  localparam int CNT_W       = 32;
  localparam int THR_W       = 14;
  localparam int BYTE_W      = 8;
  localparam int PROD_W      = CNT_W + THR_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int TDATA_OUT_W = 104;

  localparam logic [CNT_W-1:0]    CNT_SAT        = '1;
  localparam logic [THR_W-1:0]    RATE_SCALE     = THR_W'(10000);
  localparam logic [OFFSET_W-1:0] MAX_OFFSET_VAL = OFFSET_W'(MAX_OFFSET);
  localparam logic [OFFSET_W-1:0] OFFSET_RST     = OFFSET_W'(32);
  localparam logic [THR_W-1:0]    THR_RST        = THR_W'(600);

  // input item kinds
  localparam logic OP_TEXT   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // configuration register indexes
  localparam logic REG_MAX_OFFSET = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] max_offset;
    logic [THR_W-1:0]    threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] text_byte;
  } q_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    pairs;
    logic [CNT_W-1:0]    total;
    logic                last;
  } rpt_item_t;

endpackage

/* hdl/offset_coincidence_counter_unit.sv */
`timescale 1ns / 1ps
// Offset coincidence counter (kappa test). Text bytes (tuser 0) are taken one
// per cycle while the input queue has room; each byte is compared with the
// previous 64 bytes, one comparator and one saturating 32-bit counter per
// offset. A finish word (tuser 1) makes the block emit one result per offset
// 1..max_offset, tlast on the final one, then clear its counters for the next
// text. A four-word input queue sits between the accept side and the counter
// bank, so up to four words are taken while a report drains before the input
// stalls. A finish holds the counter bank while it reports each offset up to
// max_offset (taken as 1 when zero and 64 when larger), emitting one result
// per cycle while the output is taken, through a product stage and an output
// register. The flag in tuser is
// set when 10000 * hits > threshold_centipercent * pairs and pairs is nonzero.
// Register writes (index 0 max_offset, index 1 threshold) are always ready.
module offset_coincidence_counter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [occ_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] text_byte
  input  logic                             s_axis_tuser,   // [0] op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [6:0] offset, [38:7] hit_count, [70:39] pairs_compared,
  // [102:71] total_bytes, [103] zero
  output logic [occ_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tuser,   // [0] above_threshold
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [occ_pkg::THR_W-1:0]        cfg_data
);
  import occ_pkg::*;

  cfg_regs_t  cfg;
  logic       q_valid;
  logic       q_pop;
  q_item_t    q_head;
  logic       rpt_valid;
  logic       rpt_ready;
  rpt_item_t  rpt_item;

  occ_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_head        (q_head)
  );

  occ_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt_item  (rpt_item)
  );

  occ_report u_report (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .rpt_valid     (rpt_valid),
    .rpt_ready     (rpt_ready),
    .rpt_item      (rpt_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hdl/occ_front.sv */
`timescale 1ns / 1ps
module occ_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [occ_pkg::BYTE_W-1:0]     s_axis_tdata,   // text_byte
  input  logic                           s_axis_tuser,   // op
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [occ_pkg::THR_W-1:0]      cfg_data,
  output occ_pkg::cfg_regs_t             cfg,
  output logic                           q_valid,
  input  logic                           q_pop,
  output occ_pkg::q_item_t               q_head
);
  import occ_pkg::*;

  q_item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                push;
  logic                pop;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid       = (count != '0);
  assign q_head        = queue[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_offset <= OFFSET_RST;
      cfg.threshold  <= THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_OFFSET: cfg.max_offset <= cfg_data[OFFSET_W-1:0];
        REG_THRESHOLD:  cfg.threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: s_axis_tuser, text_byte: s_axis_tdata};
    end
  end

endmodule

/* hdl/occ_back.sv */
`timescale 1ns / 1ps
module occ_back (
  input  logic                 clk,
  input  logic                 rst,
  input  occ_pkg::cfg_regs_t   cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  occ_pkg::q_item_t     q_head,
  output logic                 rpt_valid,
  input  logic                 rpt_ready,
  output occ_pkg::rpt_item_t   rpt_item
);
  import occ_pkg::*;

  typedef enum logic {ST_IDLE, ST_REPORT} state_t;

  state_t                 state;
  logic [BYTE_W-1:0]      history [MAX_OFFSET];
  logic [MAX_OFFSET-1:0]  hist_valid;
  logic [CNT_W-1:0]       hits [MAX_OFFSET];
  logic [CNT_W-1:0]       byte_total;
  logic [OFFSET_W-1:0]    k;
  logic [OFFSET_W-1:0]    m_eff;
  logic [OFFSET_W-1:0]    m_eff_next;
  logic [CNT_W-1:0]       pairs;

  always_comb begin
    if (cfg.max_offset == '0) begin
      m_eff_next = OFFSET_W'(1);
    end else if (cfg.max_offset > MAX_OFFSET_VAL) begin
      m_eff_next = MAX_OFFSET_VAL;
    end else begin
      m_eff_next = cfg.max_offset;
    end
  end

  assign q_pop     = (state == ST_IDLE);
  assign rpt_valid = (state == ST_REPORT);
  assign rpt_item  = '{offset: k, hits: hits[0], pairs: pairs, total: byte_total,
                       last: (k == m_eff)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hist_valid <= '0;
      byte_total <= '0;
      k          <= OFFSET_W'(1);
      m_eff      <= OFFSET_W'(1);
      pairs      <= '0;
      for (int i = 0; i < MAX_OFFSET; i++) begin
        hits[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_head.op == OP_TEXT) begin
              // one comparator per offset against the shifted history
              for (int i = 0; i < MAX_OFFSET; i++) begin
                if (hist_valid[i] && history[i] == q_head.text_byte &&
                    hits[i] != CNT_SAT) begin
                  hits[i] <= hits[i] + 1'b1;
                end
              end
              hist_valid <= {hist_valid[MAX_OFFSET-2:0], 1'b1};
              if (byte_total != CNT_SAT) begin
                byte_total <= byte_total + 1'b1;
              end
            end else begin
              state <= ST_REPORT;
              k     <= OFFSET_W'(1);
              m_eff <= m_eff_next;
              pairs <= (byte_total == '0) ? '0 : byte_total - 1'b1;
            end
          end
        end
        ST_REPORT: begin
          if (rpt_ready) begin
            if (k == m_eff) begin
              // report done: clear text state
              state      <= ST_IDLE;
              hist_valid <= '0;
              byte_total <= '0;
              for (int i = 0; i < MAX_OFFSET; i++) begin
                hits[i] <= '0;
              end
            end else begin
              // advance counters toward the read tap
              for (int i = 0; i < MAX_OFFSET - 1; i++) begin
                hits[i] <= hits[i+1];
              end
              hits[MAX_OFFSET-1] <= '0;
              k     <= k + 1'b1;
              pairs <= (pairs == '0) ? '0 : pairs - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_head.op == OP_TEXT) begin
      history[0] <= q_head.text_byte;
      for (int i = 1; i < MAX_OFFSET; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

endmodule

/* hdl/occ_report.sv */
`timescale 1ns / 1ps
module occ_report (
  input  logic                              clk,
  input  logic                              rst,
  input  occ_pkg::cfg_regs_t                cfg,
  input  logic                              rpt_valid,
  output logic                              rpt_ready,
  input  occ_pkg::rpt_item_t                rpt_item,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [occ_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import occ_pkg::*;

  logic              a_valid;
  rpt_item_t         a_item;
  logic [PROD_W-1:0] a_lhs;
  logic [PROD_W-1:0] a_rhs;
  logic              a_nz;
  logic              out_free;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign rpt_ready = !a_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (rpt_ready) begin
        a_valid <= rpt_valid;
      end
      if (out_free) begin
        m_axis_tvalid <= a_valid;
      end
    end
  end

  // product stage: both sides of the rate compare
  always_ff @(posedge clk) begin
    if (rpt_ready && rpt_valid) begin
      a_item <= rpt_item;
      a_lhs  <= PROD_W'(rpt_item.hits) * PROD_W'(RATE_SCALE);
      a_rhs  <= PROD_W'(rpt_item.pairs) * PROD_W'(cfg.threshold);
      a_nz   <= (rpt_item.pairs != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && a_valid) begin
      m_axis_tdata <= {1'b0, a_item.total, a_item.pairs, a_item.hits, a_item.offset};
      m_axis_tuser <= a_nz && (a_lhs > a_rhs);
      m_axis_tlast <= a_item.last;
    end
  end

endmodule

/* hdl/occ_checker.sv */
`timescale 1ns / 1ps
`include "offset_coincidence_counter_unit_defines.svh"
module occ_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [occ_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             cfg_ready
);
  import occ_pkg::*;

  `OCC_ASSERT_ALWAYS(a_rst_no_out, clk, rst, !m_axis_tvalid, "result valid after reset")
  `OCC_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `OCC_ASSERT_NOW(a_offset_range, clk, rst, m_axis_tvalid, m_axis_tdata[6:0] != 7'd0 && m_axis_tdata[6:0] <= 7'd64, "offset out of range")
  `OCC_ASSERT_NOW(a_flag_pairs, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[70:39] != 32'd0, "flag set with no pairs compared")
  `OCC_ASSERT_NOW(a_cfg_ready, clk, rst, 1'b1, cfg_ready, "register write stalled")

endmodule

bind offset_coincidence_counter_unit occ_checker u_occ_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready     (cfg_ready)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import occ_pkg::*;

  localparam int DRAIN_CYCLES = 24;   // input queue depth plus report pipeline, with margin
  localparam int IDLE_PCT     = 19;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    pairs;
    logic                above;
    logic [CNT_W-1:0]    total;
    logic                last;
  } offset_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tuser = OP_TEXT;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = REG_MAX_OFFSET;
  logic [THR_W-1:0]       cfg_data = '0;

  offset_coincidence_counter_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // text state and register copies for prediction
  logic [BYTE_W-1:0]   text_window [MAX_OFFSET];
  logic [CNT_W-1:0]    hit_tally [MAX_OFFSET];
  logic [CNT_W-1:0]    text_len;
  logic [OFFSET_W-1:0] max_offset_reg;
  logic [THR_W-1:0]    threshold_reg;

  offset_report_t pending_reports[$];

  bit src_gaps;
  bit sink_gaps;
  int n_mismatch;
  int n_words_sent;
  int n_finishes;
  int n_reports_seen;
  int n_reg_writes;

  function automatic void log_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  function automatic void clear_text();
    for (int k = 0; k < MAX_OFFSET; k++) begin
      text_window[k] = '0;
      hit_tally[k]   = '0;
    end
    text_len = '0;
  endfunction

  function automatic void absorb_text_byte(input logic [BYTE_W-1:0] b);
    // every offset counts, whatever max_offset holds
    for (int k = 1; k <= MAX_OFFSET; k++)
      if (text_len >= k && text_window[k-1] == b && hit_tally[k-1] != CNT_SAT)
        hit_tally[k-1]++;
    for (int k = MAX_OFFSET - 1; k > 0; k--)
      text_window[k] = text_window[k-1];
    text_window[0] = b;
    if (text_len != CNT_SAT)
      text_len++;
  endfunction

  function automatic void queue_offset_reports();
    int               last_off;
    logic [CNT_W-1:0] pairs;
    offset_report_t   r;
    if (max_offset_reg == 0)
      last_off = 1;
    else if (max_offset_reg > MAX_OFFSET)
      last_off = MAX_OFFSET;
    else
      last_off = int'(max_offset_reg);
    for (int k = 1; k <= last_off; k++) begin
      pairs    = (text_len > k) ? text_len - CNT_W'(k) : '0;
      r.offset = OFFSET_W'(k);
      r.hits   = hit_tally[k-1];
      r.pairs  = pairs;
      r.above  = (pairs != 0) &&
                 (64'(RATE_SCALE) * 64'(hit_tally[k-1]) > 64'(threshold_reg) * 64'(pairs));
      r.total  = text_len;
      r.last   = (k == last_off);
      pending_reports.push_back(r);
    end
    clear_text();
  endfunction

  function automatic logic [THR_W-1:0] pick_max_offset();
    logic [THR_W-1:0]    w;
    logic [OFFSET_W-1:0] m;
    case ($urandom_range(5))
      0: m = '0;
      1: m = OFFSET_W'(1);
      2: m = MAX_OFFSET_VAL;
      3: m = OFFSET_W'($urandom_range(2**OFFSET_W - 1, MAX_OFFSET + 1));
      default: m = OFFSET_W'($urandom_range(MAX_OFFSET, 1));
    endcase
    // bits above the register width are dropped by the block
    w = THR_W'($urandom);
    w[OFFSET_W-1:0] = m;
    return w;
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0: return '0;
      1: return RATE_SCALE;
      2: return '1;
      3: return THR_W'($urandom_range(2**THR_W - 1, int'(RATE_SCALE) + 1));
      4: return THR_W'($urandom);
      default: return THR_W'($urandom_range(1500));
    endcase
  endfunction

  // Call at a clock edge; leaves tvalid high so back-to-back words need no toggle.
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
    while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    n_words_sent++;
    if (op == OP_FINISH) begin
      n_finishes++;
      queue_offset_reports();
    end else begin
      absorb_text_byte(b);
    end
  endtask

  task automatic drain_to_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // text words still in the input queue produce no result; let them retire
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_OFFSET)
      max_offset_reg = val[OFFSET_W-1:0];
    else
      threshold_reg = val;
    n_reg_writes++;
  endtask

  // alphabet 0 draws from all byte values, otherwise from a few symbols around a random base
  task automatic send_text(input int len, input int alphabet);
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] sym;
    int                cut;
    base = BYTE_W'($urandom);
    cut  = ($urandom_range(5) == 0) ? int'($urandom_range(len)) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        // counting goes on for all offsets; only the report length moves
        drain_to_idle();
        write_reg(REG_MAX_OFFSET, pick_max_offset());
      end
      if (alphabet == 0)
        sym = BYTE_W'($urandom);
      else
        sym = base ^ BYTE_W'($urandom_range(alphabet - 1));
      send_item(OP_TEXT, sym);
    end
    send_item(OP_FINISH, BYTE_W'($urandom));
  endtask

  task automatic test_empty_text();
    // reset values: 32 offsets, all counts zero
    send_item(OP_FINISH, 8'hFF);
  endtask

  task automatic test_extreme_bytes();
    logic [BYTE_W-1:0] pattern [8] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h55};
    drain_to_idle();
    write_reg(REG_MAX_OFFSET, THR_W'(4));
    write_reg(REG_THRESHOLD, '0);
    foreach (pattern[i])
      send_item(OP_TEXT, pattern[i]);
    send_item(OP_FINISH, 8'h00);
  endtask

  task automatic test_offset_limits();
    drain_to_idle();
    write_reg(REG_MAX_OFFSET, '0);
    send_item(OP_FINISH, 8'h80);
    send_item(OP_TEXT, 8'h3C);
    send_item(OP_TEXT, 8'h3C);
    send_item(OP_FINISH, 8'h7F);
    drain_to_idle();
    write_reg(REG_MAX_OFFSET, THR_W'(2**OFFSET_W - 1));
    write_reg(REG_THRESHOLD, '1);
    repeat (3) send_item(OP_TEXT, 8'h81);
    send_item(OP_FINISH, 8'h01);
    drain_to_idle();
    write_reg(REG_MAX_OFFSET, THR_W'(MAX_OFFSET));
    write_reg(REG_THRESHOLD, RATE_SCALE - 1'b1);
    repeat (4) send_item(OP_TEXT, 8'hE7);
    send_item(OP_FINISH, 8'h18);
  endtask

  task automatic test_back_to_back();
    int stop_at;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    drain_to_idle();
    write_reg(REG_MAX_OFFSET, pick_max_offset());
    write_reg(REG_THRESHOLD, pick_threshold());
    stop_at = n_words_sent + 30;
    while (n_words_sent < stop_at)
      send_text($urandom_range(12), $urandom_range(4));
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_random_texts();
    int stop_at;
    int len;
    stop_at = n_words_sent + 60;
    while (n_words_sent < stop_at) begin
      if ($urandom_range(2) == 0) begin
        drain_to_idle();
        write_reg(REG_MAX_OFFSET, pick_max_offset());
        write_reg(REG_THRESHOLD, pick_threshold());
      end
      // now and then a text long enough to fill the whole window
      if ($urandom_range(7) == 0)
        len = $urandom_range(MAX_OFFSET + 8, MAX_OFFSET + 1);
      else
        len = $urandom_range(12);
      send_text(len, $urandom_range(4));
    end
  endtask

  always @(posedge clk) begin : result_check
    offset_report_t seen;
    offset_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.offset = m_axis_tdata[OFFSET_W-1:0];
      seen.hits   = m_axis_tdata[OFFSET_W +: CNT_W];
      seen.pairs  = m_axis_tdata[OFFSET_W + CNT_W +: CNT_W];
      seen.total  = m_axis_tdata[OFFSET_W + 2*CNT_W +: CNT_W];
      seen.above  = m_axis_tuser;
      seen.last   = m_axis_tlast;
      n_reports_seen++;
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("result for offset %0d with none expected", seen.offset));
      end else begin
        want = pending_reports.pop_front();
        if (seen !== want || m_axis_tdata[TDATA_OUT_W-1] !== 1'b0)
          log_mismatch($sformatf(
            {"exp/act offset %0d/%0d hits %0d/%0d pairs %0d/%0d flag %0b/%0b ",
             "total %0d/%0d last %0b/%0b pad %0b"},
            want.offset, seen.offset, want.hits, seen.hits, want.pairs, seen.pairs,
            want.above, seen.above, want.total, seen.total, want.last, seen.last,
            m_axis_tdata[TDATA_OUT_W-1]));
      end
    end
    m_axis_tready <= !(sink_gaps && $urandom_range(99) < IDLE_PCT);
  end

  initial begin
    clear_text();
    max_offset_reg = OFFSET_RST;
    threshold_reg  = THR_RST;
    src_gaps       = 1'b1;
    sink_gaps      = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_text();
    test_extreme_bytes();
    test_offset_limits();
    test_back_to_back();
    test_random_texts();
    drain_to_idle();

    $display("Sent %0d words in %0d texts, checked %0d offset results, %0d register writes",
             n_words_sent, n_finishes, n_reports_seen, n_reg_writes);
    $display("Mismatches: %0d, results still expected: %0d",
             n_mismatch, pending_reports.size());
    if (n_mismatch == 0 && pending_reports.size() == 0)
      $display("** offset_coincidence_counter_unit: PASSED **");
    else
      $display("** offset_coincidence_counter_unit: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results still expected", pending_reports.size());
    $display("** offset_coincidence_counter_unit: FAILED **");
    $finish;
  end

endmodule
